[hdl/pfs_pkg.sv]
// Shared types and codes for the pinned FIFO store.
package pfs_pkg;

   // Operation codes carried by req_mode.
   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_FIND  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // Result codes carried by rsp_status.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY_ID  = 3'd1,
      STATUS_EXCEEDS   = 3'd2,
      STATUS_PINNED    = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   // Configuration register indexes.
   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_MAX_BYTES   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_SCAN,
      S_CHECK,
      S_COMMIT
   } fsm_state_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic rotate;   // whole chain moves one place towards the head
      logic remove;   // cells at and above the oldest marked entry close the gap
      logic mark;     // load the evict marks from the key comparison
      logic append;   // the selected cell takes the new entry
   } cell_ctl_type;

endpackage

[hdl/pinned_fifo_store.sv]
// Top level of the pinned FIFO store: sequencer and chain of storage cells.
//
// A command is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_strobe high and cannot be
// held off, so the receiver must take it then. Find, clear and the no-op mode
// are answered after the key match, as is a put refused for an empty id or an
// oversized entry. A put that succeeds goes on past the match: the entries
// rotate once through the chain head, one a cycle, to decide which are
// evicted, and the removals then close their gaps one at a time before the
// new entry is appended. A put refused because only pinned entries are left
// ends after the rotation and changes nothing.
// Configuration writes are taken at any time but belong in idle periods.
module pinned_fifo_store
   import pfs_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_size,
   input  logic [15:0] req_pin_mask,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_found_size,
   output logic [4:0]  rsp_evicted_count,
   output logic [4:0]  rsp_entry_count,
   output logic [31:0] rsp_used_bytes,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PW  = $clog2(DEPTH);
   localparam int CMW = (CW > 5) ? CW : 5;
   localparam int PMW = (DEPTH > 16) ? DEPTH : 16;

   fsm_state_type state_ff, state_in;

   logic [1:0]          mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         size_ff, size_in;
   logic [15:0]         pins_ff, pins_in;
   logic [4:0]          max_entries_ff;
   logic [31:0]         max_bytes_ff;
   logic [CW-1:0]       held_ff, held_in;
   logic [31:0]         total_ff, total_in;
   logic [31:0]         wt_ff, wt_in;
   logic                neg_ff, neg_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       removed_ff, removed_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [31:0]         lim_ff, lim_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_found_ff, rsp_found_in;
   logic [4:0]  rsp_evicted_ff, rsp_evicted_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_used_ff, rsp_used_in;

   cell_ctl_type ctl;

   logic [KEY_BITS-1:0] c_key  [DEPTH];
   logic [31:0]         c_size [DEPTH];
   logic [DEPTH-1:0]    c_gone, c_eq, c_del, c_load, match_vec;
   logic                head_gone_new;

   logic [31:0]    sel_size;
   logic [CMW-1:0] me_ext, cap;
   logic           need, evict, any_match;
   logic [PMW-1:0] pins_ext;
   logic [DEPTH-1:0] pin_vec;
   logic [32:0]    dup_diff, scan_diff;

   // ---------------------------------------------------------------- chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] nb_key;
      logic [31:0]         nb_size;
      logic                nb_gone;

      if (i < DEPTH - 1) begin : g_mid
         assign nb_key  = c_key[i+1];
         assign nb_size = c_size[i+1];
         assign nb_gone = c_gone[i+1];
      end else begin : g_last
         // The tail takes the head back on rotation; on removal it keeps its
         // own contents, now unused, with the mark cleared.
         assign nb_key  = ctl.rotate ? c_key[0]  : c_key[DEPTH-1];
         assign nb_size = ctl.rotate ? c_size[0] : c_size[DEPTH-1];
         assign nb_gone = ctl.rotate ? head_gone_new : 1'b0;
      end

      if (i == 0) begin : g_del0
         assign c_del[i] = c_gone[i];
      end else begin : g_deln
         assign c_del[i] = c_del[i-1] | c_gone[i];
      end

      assign c_load[i]    = (n_ff == CW'(i));
      assign match_vec[i] = c_eq[i] && (CW'(i) < held_ff);

      pfs_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .shift_sel (c_del[i]),
         .load_sel  (c_load[i]),
         .mark_val  (match_vec[i]),
         .cmp_key   (key_ff),
         .nb_key    (nb_key),
         .nb_size   (nb_size),
         .nb_gone   (nb_gone),
         .new_key   (key_ff),
         .new_size  (size_ff),
         .key       (c_key[i]),
         .size      (c_size[i]),
         .gone      (c_gone[i]),
         .key_eq    (c_eq[i])
      );
   end

   // Keys are unique in the store, so at most one cell matches.
   always_comb begin
      sel_size = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_vec[i]) begin
            sel_size = sel_size | c_size[i];
         end
      end
   end

   assign any_match = |match_vec;
   assign me_ext    = CMW'(max_entries_ff);
   assign cap       = (me_ext > CMW'(DEPTH)) ? CMW'(DEPTH) : me_ext;
   assign need      = (CMW'(n_ff) >= cap) || neg_ff || (wt_ff > lim_ff);
   assign pins_ext  = PMW'(pins_ff);
   assign pin_vec   = pins_ext[DEPTH-1:0];
   assign evict     = (CW'(pos_ff) < held_ff) && !c_gone[0] && !pin_vec[pos_ff] && need;
   assign head_gone_new = c_gone[0] | evict;
   assign dup_diff  = {1'b0, total_ff} - {1'b0, sel_size};
   assign scan_diff = {1'b0, wt_ff} - {1'b0, c_size[0]};

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_MATCH;
         end
         S_MATCH: begin
            if ((mode_ff == MODE_PUT) && (key_ff != '0) && (cap != '0)
                && (size_ff <= max_bytes_ff)) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (pos_ff == PW'(DEPTH - 1)) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = need ? S_IDLE : S_COMMIT;
         end
         S_COMMIT: begin
            if (!(|c_gone)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------- outputs
   always_comb begin
      ctl            = '0;
      mode_in        = mode_ff;
      key_in         = key_ff;
      size_in        = size_ff;
      pins_in        = pins_ff;
      held_in        = held_ff;
      total_in       = total_ff;
      wt_in          = wt_ff;
      neg_in         = neg_ff;
      n_in           = n_ff;
      removed_in     = removed_ff;
      pos_in         = pos_ff;
      lim_in         = lim_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_used_in    = rsp_used_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               key_in  = KEY_BITS'(req_key);
               size_in = req_size;
               pins_in = req_pin_mask;
            end
         end
         S_MATCH: begin
            rsp_status_in  = STATUS_OK;
            rsp_found_in   = '0;
            rsp_evicted_in = '0;
            rsp_count_in   = 5'(held_ff);
            rsp_used_in    = total_ff;
            case (mode_ff)
               MODE_PUT: begin
                  if (key_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_EMPTY_ID;
                  end else if ((cap == '0) || (size_ff > max_bytes_ff)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_EXCEEDS;
                  end else begin
                     // An older entry with the same key goes first.
                     ctl.mark   = 1'b1;
                     wt_in      = any_match ? dup_diff[31:0] : total_ff;
                     neg_in     = any_match & dup_diff[32];
                     n_in       = held_ff - CW'(any_match);
                     removed_in = CW'(any_match);
                     lim_in     = max_bytes_ff - size_ff;
                     pos_in     = '0;
                  end
               end
               MODE_FIND: begin
                  rsp_strobe_in = 1'b1;
                  if ((key_ff != '0) && any_match) begin
                     rsp_found_in = sel_size;
                  end else begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               end
               MODE_CLEAR: begin
                  rsp_strobe_in = 1'b1;
                  held_in       = '0;
                  total_in      = '0;
                  rsp_count_in  = '0;
                  rsp_used_in   = '0;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            // The entry at the head is the one at age position pos_ff.
            ctl.rotate = 1'b1;
            pos_in     = pos_ff + 1'b1;
            if (evict) begin
               wt_in      = scan_diff[31:0];
               neg_in     = neg_ff | scan_diff[32];
               n_in       = n_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (need) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_PINNED;
               rsp_found_in   = '0;
               rsp_evicted_in = '0;
               rsp_count_in   = 5'(held_ff);
               rsp_used_in    = total_ff;
            end
         end
         S_COMMIT: begin
            if (|c_gone) begin
               ctl.remove = 1'b1;
            end else begin
               ctl.append     = 1'b1;
               held_in        = CW'(n_ff + 1'b1);
               total_in       = wt_ff + size_ff;
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_found_in   = '0;
               rsp_evicted_in = 5'(removed_ff);
               rsp_count_in   = 5'(CW'(n_ff + 1'b1));
               rsp_used_in    = wt_ff + size_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         held_ff        <= '0;
         total_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
         max_entries_ff <= 5'd16;
         max_bytes_ff   <= '1;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_ENTRIES: max_entries_ff <= csr_write_data[4:0];
               CSR_MAX_BYTES:   max_bytes_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      size_ff        <= size_in;
      pins_ff        <= pins_in;
      wt_ff          <= wt_in;
      neg_ff         <= neg_in;
      n_ff           <= n_in;
      removed_ff     <= removed_in;
      pos_ff         <= pos_in;
      lim_ff         <= lim_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_size    = rsp_found_ff;
   assign rsp_evicted_count = rsp_evicted_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_used_bytes    = rsp_used_ff;

endmodule

[hdl/pfs_cell.sv]
// One storage cell of the chain: a key, a size and an evict mark.
module pfs_cell
   import pfs_pkg::*;
#(
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic                shift_sel,
   input  logic                load_sel,
   input  logic                mark_val,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  logic [KEY_BITS-1:0] nb_key,
   input  logic [31:0]         nb_size,
   input  logic                nb_gone,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [31:0]         new_size,
   output logic [KEY_BITS-1:0] key,
   output logic [31:0]         size,
   output logic                gone,
   output logic                key_eq
);

   logic [KEY_BITS-1:0] key_ff;
   logic [31:0]         size_ff;
   logic                gone_ff;

   always_ff @(posedge clock) begin
      if (ctl.rotate || (ctl.remove && shift_sel)) begin
         key_ff  <= nb_key;
         size_ff <= nb_size;
         gone_ff <= nb_gone;
      end else if (ctl.append && load_sel) begin
         key_ff  <= new_key;
         size_ff <= new_size;
         gone_ff <= 1'b0;
      end else if (ctl.mark) begin
         gone_ff <= mark_val;
      end
   end

   assign key    = key_ff;
   assign size   = size_ff;
   assign gone   = gone_ff;
   assign key_eq = (key_ff == cmp_key);

endmodule

[hdl/pfs_checker.sv]
// Port-level checks for the pinned FIFO store, bound to the top level.
module pfs_checker
   import pfs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_found_size,
   input logic [4:0]  rsp_evicted_count
);

   // A result beat is never followed directly by another.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat lasted more than one cycle");

   // An accepted command makes the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted but block not busy");

   // The block goes idle only as it delivers the result of the command.
   a_result_on_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("block went idle without a result beat");

   // A failed command reports no entries removed.
   a_evict_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_evicted_count == 5'd0))
      else $error("entries reported removed by a failed command");

   // A miss reports no size.
   a_miss_no_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_NOT_FOUND)) |-> (rsp_found_size == 32'd0))
      else $error("size reported on a miss");

endmodule

bind pinned_fifo_store pfs_checker u_pfs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_found_size    (rsp_found_size),
   .rsp_evicted_count (rsp_evicted_count)
);

[tb/sv/pfs_checker.sv]
// Checker for the pinned FIFO store: predicts each command's result and compares.
`timescale 1ns / 1ps
module pfs_scoreboard
   import pfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_size,
   input  logic [15:0] req_pin_mask,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_found_size,
   input  logic [4:0]  rsp_evicted_count,
   input  logic [4:0]  rsp_entry_count,
   input  logic [31:0] rsp_used_bytes,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   localparam int SLOTS = 16;

   typedef struct packed {
      status_type  status;
      logic [31:0] found_size;
      logic [4:0]  evicted;
      logic [4:0]  held;
      logic [31:0] used;
   } outcome_type;

   logic [4:0]  lim_entries;
   logic [31:0] lim_bytes;
   logic [31:0] slot_key  [SLOTS];
   logic [31:0] slot_size [SLOTS];
   int          held_entries;
   logic [31:0] held_bytes;
   outcome_type awaited_outcomes[$];

   function automatic int locate_key(logic [31:0] k);
      for (int i = 0; i < held_entries; i++)
         if (slot_key[i] == k) return i;
      return -1;
   endfunction

   function automatic outcome_type apply_command(mode_type m, logic [31:0] k,
                                                 logic [31:0] sz, logic [15:0] pins);
      outcome_type r;
      bit          gone [SLOTS];
      int          cap, n, dup, victim, w;
      longint      total;
      bit          fits;
      r = '0;
      r.status = STATUS_OK;
      cap = (lim_entries < SLOTS) ? lim_entries : SLOTS;
      case (m)
         MODE_PUT: begin
            if (k == 0) begin
               r.status = STATUS_EMPTY_ID;
            end else if (cap == 0 || sz > lim_bytes) begin
               r.status = STATUS_EXCEEDS;
            end else begin
               foreach (gone[i]) gone[i] = 0;
               n = held_entries;
               total = held_bytes;
               fits = 1;
               dup = locate_key(k);
               if (dup >= 0) begin
                  gone[dup] = 1;
                  total -= slot_size[dup];
                  n--;
                  r.evicted++;
               end
               // Evict the oldest unpinned entries, positions as held before the put.
               while (n >= cap || total > longint'(lim_bytes) - longint'(sz)) begin
                  victim = -1;
                  for (int i = 0; i < held_entries; i++)
                     if (!gone[i] && !pins[i]) begin
                        victim = i;
                        break;
                     end
                  if (victim < 0) begin
                     fits = 0;
                     break;
                  end
                  gone[victim] = 1;
                  total -= slot_size[victim];
                  n--;
                  r.evicted++;
               end
               if (!fits) begin
                  r.status = STATUS_PINNED;
                  r.evicted = 0;
               end else begin
                  w = 0;
                  for (int i = 0; i < held_entries; i++)
                     if (!gone[i]) begin
                        slot_key[w] = slot_key[i];
                        slot_size[w] = slot_size[i];
                        w++;
                     end
                  slot_key[w] = k;
                  slot_size[w] = sz;
                  held_entries = w + 1;
                  held_bytes = 32'(total + sz);
               end
            end
         end
         MODE_FIND: begin
            dup = locate_key(k);
            if (k != 0 && dup >= 0) r.found_size = slot_size[dup];
            else r.status = STATUS_NOT_FOUND;
         end
         MODE_CLEAR: begin
            held_entries = 0;
            held_bytes = '0;
         end
         default: ;
      endcase
      r.held = 5'(held_entries);
      r.used = held_bytes;
      return r;
   endfunction

   task automatic note_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         lim_entries = 5'd16;
         lim_bytes = 32'hFFFF_FFFF;
         held_entries = 0;
         held_bytes = '0;
         awaited_outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_outcomes.size() == 0) begin
               if (fail_count < 10) $display("%0t: result beat with none expected", $realtime);
               fail_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               note_field("status", want.status, rsp_status);
               note_field("found_size", want.found_size, rsp_found_size);
               note_field("evicted_count", want.evicted, rsp_evicted_count);
               note_field("entry_count", want.held, rsp_entry_count);
               note_field("used_bytes", want.used, rsp_used_bytes);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_MAX_ENTRIES) lim_entries = csr_write_data[4:0];
            else lim_bytes = csr_write_data;
         end
         if (start && !busy)
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    apply_command(mode_type'(req_mode), req_key,
                                                  req_size, req_pin_mask));
      end
      pending = awaited_outcomes.size();
   end
endmodule

[tb/sv/tb_pinned_fifo_store.sv]
// Testbench top for the pinned FIFO store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_pinned_fifo_store;
   import pfs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 48;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_key = '0;
   logic [31:0] req_size = '0;
   logic [15:0] req_pin_mask = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_found_size;
   logic [4:0]  rsp_evicted_count;
   logic [4:0]  rsp_entry_count;
   logic [31:0] rsp_used_bytes;
   logic        csr_write_enable = 0;
   logic        csr_index = CSR_MAX_ENTRIES;
   logic [31:0] csr_write_data = '0;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   bit          quiet_tail = 0;
   logic [31:0] byte_scale;

   always #5 clock = ~clock;

   pinned_fifo_store u_top (.*);
   pfs_scoreboard u_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Drives one command from a falling edge and returns at the falling edge after its
   // acceptance; unless it pauses at random, start is left high for back-to-back commands.
   task automatic issue(mode_type m, logic [31:0] k, logic [31:0] sz, logic [15:0] pins);
      start = 1;
      req_mode = m;
      req_key = k;
      req_size = sz;
      req_pin_mask = pins;
      #1;
      while (busy) @(negedge clock);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start = 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic set_register(logic idx, logic [31:0] value);
      start = 0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic random_command();
      logic [31:0] k, sz;
      logic [15:0] pins;
      int          pick;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       k = $urandom();
         1:       k = 0;
         default: k = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 7))
         0:       sz = $urandom();
         1:       sz = byte_scale;
         default: sz = $urandom_range(0, byte_scale / 6 + 1);
      endcase
      case ($urandom_range(0, 3))
         0:       pins = $urandom();
         1:       pins = 16'(1 << $urandom_range(0, 15));
         default: pins = '0;
      endcase
      if (pick < 55)      issue(MODE_PUT, k, sz, pins);
      else if (pick < 88) issue(MODE_FIND, k, sz, pins);
      else if (pick < 94) issue(MODE_CLEAR, k, sz, pins);
      else                issue(MODE_NOP, k, sz, pins);
   endtask

   initial begin
      logic [4:0]  entry_plan [6] = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd2, 5'd16};
      logic [31:0] byte_plan  [6] = '{32'hFFFF_FFFF, 32'd1000, 32'd5000, 32'hFFFF_FFFF,
                                      32'd300, 32'd100000};
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed commands under the reset budgets.
      issue(MODE_PUT, 32'd0, 32'd5, '0);
      issue(MODE_FIND, 32'd0, '0, '0);
      issue(MODE_FIND, 32'd7, '0, '0);
      issue(MODE_PUT, 32'd7, 32'd100, '0);
      issue(MODE_PUT, 32'd7, 32'd250, '0);
      issue(MODE_FIND, 32'd7, '0, '0);
      issue(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      issue(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      issue(MODE_CLEAR, '0, '0, '0);
      for (int i = 1; i <= 16; i++) issue(MODE_PUT, 32'(i), 32'(i), '0);
      // A full store with every held entry pinned cannot take another one.
      issue(MODE_PUT, 32'd99, 32'd1, 16'hFFFF);
      issue(MODE_PUT, 32'd99, 32'd1, 16'h7FFF);
      issue(MODE_FIND, 32'd16, '0, '0);

      set_register(CSR_MAX_ENTRIES, 32'd0);
      issue(MODE_PUT, 32'd3, 32'd1, '0);
      set_register(CSR_MAX_ENTRIES, 32'd31);
      set_register(CSR_MAX_BYTES, 32'd0);
      issue(MODE_PUT, 32'd5, 32'd1, '0);
      issue(MODE_PUT, 32'd5, 32'd0, 16'h0001);
      issue(MODE_FIND, 32'd5, '0, '0);

      // Random phases, each under its own pair of budgets.
      for (int phase = 0; phase < 6; phase++) begin
         set_register(CSR_MAX_ENTRIES, 32'(entry_plan[phase]));
         set_register(CSR_MAX_BYTES, byte_plan[phase]);
         byte_scale = (byte_plan[phase] > 32'd2000) ? 32'd2000 : byte_plan[phase];
         if (phase == 5) quiet_tail = 1;
         repeat (75) random_command();
      end

      start = 0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
